// File: rtl/nfr_pkg.sv
// ----------------------------------------------------------------------------
// nfr_pkg
// Shared constants, types and helpers for the normalized feature response
// unit.
// ----------------------------------------------------------------------------
package nfr_pkg;

   localparam int MAX_FEATURES = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int POS_BITS     = $clog2(MAX_FEATURES);
   localparam int INDEX_BITS   = 5;
   localparam int COUNT_BITS   = 6;
   localparam int PROD_BITS    = 2 * SAMPLE_BITS;
   localparam int ACC_BITS     = 48;
   localparam int RESP_BITS    = 32;

   // Normalizer datapath widths
   localparam int RADICAND_BITS = 64;
   localparam int ROOT_BITS     = RADICAND_BITS / 2;
   localparam int REM_BITS      = ROOT_BITS + 3;
   localparam int QUOT_BITS     = 64;
   localparam int STEP_BITS     = $clog2(QUOT_BITS);

   localparam logic [COUNT_BITS-1:0] RESET_FEATURE_COUNT = COUNT_BITS'(31);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_FEATURE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      NORM_IDLE,
      NORM_CHECK,
      NORM_ROOT,
      NORM_DIVIDE,
      NORM_DONE
   } norm_state_type;

   // Finished sums of one location, handed to the normalizer
   typedef struct packed {
      logic                       valid;
      logic signed [ACC_BITS-1:0] dot;
      logic [ACC_BITS-1:0]        square;
      logic                       last;
   } handoff_type;

   // Saturate a sign and magnitude to signed 32 bits
   function automatic logic [RESP_BITS-1:0] sat_response(
      input logic                 neg,
      input logic [QUOT_BITS-1:0] mag
   );
      logic big;
      big = (mag[QUOT_BITS-1:RESP_BITS-1] != '0);
      if (neg) begin
         if (big) begin
            return {1'b1, {(RESP_BITS-1){1'b0}}};
         end
         return (~mag[RESP_BITS-1:0]) + RESP_BITS'(1);
      end
      if (big) begin
         return {1'b0, {(RESP_BITS-1){1'b1}}};
      end
      return mag[RESP_BITS-1:0];
   endfunction

endpackage

// File: rtl/nfr_weight_ram.sv
// ----------------------------------------------------------------------------
// nfr_weight_ram
// Filter weight store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfr_weight_ram (
   input  logic                               clock,
   input  logic                               write_enable,
   input  logic [nfr_pkg::POS_BITS-1:0]       write_addr,
   input  logic [nfr_pkg::SAMPLE_BITS-1:0]    write_data,
   input  logic                               read_enable,
   input  logic [nfr_pkg::POS_BITS-1:0]       read_addr,
   output logic [nfr_pkg::SAMPLE_BITS-1:0]    read_data_ff
);

   logic [nfr_pkg::SAMPLE_BITS-1:0] mem [nfr_pkg::MAX_FEATURES];

   // write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

endmodule

// File: rtl/nfr_accum.sv
// ----------------------------------------------------------------------------
// nfr_accum
// Feature front end: tracks the position in a location, reads the matching
// weight, forms both products and accumulates the dot and square sums.
// ----------------------------------------------------------------------------
module nfr_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                feature_accept,
   input  logic                                load_accept,
   input  logic [nfr_pkg::INDEX_BITS-1:0]      weight_index,
   input  logic signed [nfr_pkg::SAMPLE_BITS-1:0] sample_value,
   input  logic                                last_location,
   input  logic [nfr_pkg::COUNT_BITS-1:0]      feature_count,
   output logic                                at_end,
   output logic                                end_in_flight,
   output nfr_pkg::handoff_type                handoff
);

   localparam int ACC_BITS  = nfr_pkg::ACC_BITS;
   localparam int PROD_BITS = nfr_pkg::PROD_BITS;
   localparam int CNT_BITS  = nfr_pkg::COUNT_BITS;

   logic [nfr_pkg::POS_BITS-1:0]            pos_ff, pos_in;
   logic [CNT_BITS-1:0]                     count_eff;
   logic [nfr_pkg::SAMPLE_BITS-1:0]         weight_data;

   logic                                    a_valid_ff, a_end_ff, a_last_ff;
   logic signed [nfr_pkg::SAMPLE_BITS-1:0]  a_sample_ff;

   logic                                    b_valid_ff, b_end_ff, b_last_ff;
   logic signed [PROD_BITS-1:0]             b_dot_prod_ff, b_dot_prod_in;
   logic [PROD_BITS-1:0]                    b_sq_prod_ff, b_sq_prod_in;
   logic signed [PROD_BITS-1:0]             sq_signed;

   logic signed [ACC_BITS-1:0]              dot_acc_ff, dot_sum;
   logic [ACC_BITS-1:0]                     sq_acc_ff, sq_sum;

   // clamp the configured count to 1..MAX_FEATURES
   always_comb begin
      if (feature_count == '0) begin
         count_eff = CNT_BITS'(1);
      end else if (feature_count > CNT_BITS'(nfr_pkg::MAX_FEATURES)) begin
         count_eff = CNT_BITS'(nfr_pkg::MAX_FEATURES);
      end else begin
         count_eff = feature_count;
      end
   end

   assign at_end = ((CNT_BITS'(pos_ff) + CNT_BITS'(1)) >= count_eff);
   assign pos_in = at_end ? '0 : pos_ff + nfr_pkg::POS_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (feature_accept) begin
         pos_ff <= pos_in;
      end
   end

   nfr_weight_ram u_weight_ram (
      .clock        (clock),
      .write_enable (load_accept),
      .write_addr   (weight_index[nfr_pkg::POS_BITS-1:0]),
      .write_data   (sample_value),
      .read_enable  (feature_accept),
      .read_addr    (pos_ff),
      .read_data_ff (weight_data)
   );

   // stage A: sample waits for its weight
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= feature_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (feature_accept) begin
         a_end_ff    <= at_end;
         a_last_ff   <= last_location;
         a_sample_ff <= sample_value;
      end
   end

   // stage B: products
   assign b_dot_prod_in = a_sample_ff * $signed(weight_data);
   assign sq_signed     = a_sample_ff * a_sample_ff;
   assign b_sq_prod_in  = sq_signed;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_end_ff      <= a_end_ff;
         b_last_ff     <= a_last_ff;
         b_dot_prod_ff <= b_dot_prod_in;
         b_sq_prod_ff  <= b_sq_prod_in;
      end
   end

   // accumulate; both sums wrap at ACC_BITS
   assign dot_sum = dot_acc_ff
                  + {{(ACC_BITS-PROD_BITS){b_dot_prod_ff[PROD_BITS-1]}}, b_dot_prod_ff};
   assign sq_sum  = sq_acc_ff + {{(ACC_BITS-PROD_BITS){1'b0}}, b_sq_prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_acc_ff <= '0;
         sq_acc_ff  <= '0;
      end else if (b_valid_ff) begin
         if (b_end_ff) begin
            dot_acc_ff <= '0;
            sq_acc_ff  <= '0;
         end else begin
            dot_acc_ff <= dot_sum;
            sq_acc_ff  <= sq_sum;
         end
      end
   end

   // finished location goes to the normalizer
   always_comb begin
      handoff.valid  = b_valid_ff & b_end_ff;
      handoff.dot    = dot_sum;
      handoff.square = sq_sum;
      handoff.last   = b_last_ff;
   end

   assign end_in_flight = (a_valid_ff & a_end_ff) | (b_valid_ff & b_end_ff);

`ifndef SYNTHESIS
   // the final features of two locations never share the pipe
   a_single_end: assert property (@(posedge clock) disable iff (reset)
      !(a_valid_ff && a_end_ff && b_valid_ff && b_end_ff))
      else $error("two location ends in flight");
`endif

endmodule

// File: rtl/nfr_norm.sv
// ----------------------------------------------------------------------------
// nfr_norm
// Normalizer: bit-serial square root of the scaled square sum, then a
// bit-serial restoring divide of the scaled dot magnitude, saturation, and
// the result output register.
// ----------------------------------------------------------------------------
module nfr_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  nfr_pkg::handoff_type               handoff,
   output logic                               busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nfr_pkg::RESP_BITS-1:0] rsp_response,
   output logic                               rsp_last_location_res
);

   localparam int ACC_BITS  = nfr_pkg::ACC_BITS;
   localparam int RAD_BITS  = nfr_pkg::RADICAND_BITS;
   localparam int ROOT_BITS = nfr_pkg::ROOT_BITS;
   localparam int REM_BITS  = nfr_pkg::REM_BITS;
   localparam int QUOT_BITS = nfr_pkg::QUOT_BITS;
   localparam int STEP_BITS = nfr_pkg::STEP_BITS;

   // small sums (below 2^SMALL_LIMIT) get the finer scale
   localparam int SMALL_LIMIT = 40;
   localparam int FINE_H      = 12;
   localparam int COARSE_H    = 8;
   localparam int FINE_SH     = 8 + FINE_H;
   localparam int COARSE_SH   = 8 + COARSE_H;
   localparam int FINE_MAG    = QUOT_BITS - 1 - FINE_SH;
   localparam int COARSE_MAG  = QUOT_BITS - 1 - COARSE_SH;

   localparam logic [STEP_BITS-1:0] ROOT_LAST = STEP_BITS'(ROOT_BITS - 1);
   localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(QUOT_BITS - 1);

   nfr_pkg::norm_state_type state_ff, state_in;

   logic signed [ACC_BITS-1:0]   dot_ff;
   logic [ACC_BITS-1:0]          square_ff;
   logic                         last_ff, neg_ff;
   logic [RAD_BITS-1:0]          radicand_ff;
   logic [ROOT_BITS-1:0]         root_ff;
   logic [REM_BITS-1:0]          rem_ff;
   logic [QUOT_BITS-1:0]         quot_ff;
   logic [STEP_BITS-1:0]         step_ff;

   logic                         rsp_valid_ff;
   logic [nfr_pkg::RESP_BITS-1:0] rsp_response_ff;
   logic                         rsp_last_ff;

   logic                         out_free, deposit;

   // check stage decode
   logic                         neg;
   logic [ACC_BITS-1:0]          mag;
   logic                         fine_scale, square_zero, too_big;

   // root step
   logic [REM_BITS-1:0]          root_shift, root_trial;
   logic                         root_fits;

   // divide step
   logic [ROOT_BITS:0]           div_shift, div_diff;
   logic                         div_fits;

   assign neg         = dot_ff[ACC_BITS-1];
   assign mag         = neg ? (~dot_ff + ACC_BITS'(1)) : dot_ff;
   assign fine_scale  = (square_ff[ACC_BITS-1:SMALL_LIMIT] == '0);
   assign square_zero = (square_ff == '0);
   assign too_big     = fine_scale ? (mag[ACC_BITS-1:FINE_MAG] != '0)
                                   : (mag[ACC_BITS-1:COARSE_MAG] != '0);

   assign root_shift = {rem_ff[REM_BITS-3:0], radicand_ff[RAD_BITS-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_fits  = (root_shift >= root_trial);

   assign div_shift = {rem_ff[ROOT_BITS-1:0], quot_ff[QUOT_BITS-1]};
   assign div_fits  = (div_shift >= {1'b0, root_ff});
   assign div_diff  = div_shift - {1'b0, root_ff};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nfr_pkg::NORM_IDLE: begin
            if (handoff.valid) begin
               state_in = nfr_pkg::NORM_CHECK;
            end
         end
         nfr_pkg::NORM_CHECK: begin
            if (square_zero || too_big) begin
               state_in = nfr_pkg::NORM_DONE;
            end else begin
               state_in = nfr_pkg::NORM_ROOT;
            end
         end
         nfr_pkg::NORM_ROOT: begin
            if (step_ff == ROOT_LAST) begin
               state_in = nfr_pkg::NORM_DIVIDE;
            end
         end
         nfr_pkg::NORM_DIVIDE: begin
            if (step_ff == DIV_LAST) begin
               state_in = nfr_pkg::NORM_DONE;
            end
         end
         nfr_pkg::NORM_DONE: begin
            if (out_free) begin
               state_in = nfr_pkg::NORM_IDLE;
            end
         end
         default: state_in = nfr_pkg::NORM_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      busy    = (state_ff != nfr_pkg::NORM_IDLE);
      deposit = (state_ff == nfr_pkg::NORM_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nfr_pkg::NORM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         nfr_pkg::NORM_IDLE: begin
            if (handoff.valid) begin
               dot_ff    <= handoff.dot;
               square_ff <= handoff.square;
               last_ff   <= handoff.last;
            end
         end
         nfr_pkg::NORM_CHECK: begin
            neg_ff  <= neg;
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
            if (square_zero) begin
               quot_ff <= QUOT_BITS'(mag);
            end else if (too_big) begin
               quot_ff <= QUOT_BITS'(64'h1_0000_0000);
            end else if (fine_scale) begin
               radicand_ff <= {square_ff[SMALL_LIMIT-1:0], {(2*FINE_H){1'b0}}};
               quot_ff     <= {1'b0, mag[FINE_MAG-1:0], {FINE_SH{1'b0}}};
            end else begin
               radicand_ff <= {square_ff, {(2*COARSE_H){1'b0}}};
               quot_ff     <= {1'b0, mag[COARSE_MAG-1:0], {COARSE_SH{1'b0}}};
            end
         end
         nfr_pkg::NORM_ROOT: begin
            rem_ff      <= root_fits ? (root_shift - root_trial) : root_shift;
            root_ff     <= {root_ff[ROOT_BITS-2:0], root_fits};
            radicand_ff <= {radicand_ff[RAD_BITS-3:0], 2'b00};
            step_ff     <= (step_ff == ROOT_LAST) ? '0 : step_ff + STEP_BITS'(1);
            if (step_ff == ROOT_LAST) begin
               rem_ff <= '0;
            end
         end
         nfr_pkg::NORM_DIVIDE: begin
            rem_ff  <= {{(REM_BITS-ROOT_BITS-1){1'b0}},
                        (div_fits ? div_diff : div_shift)};
            quot_ff <= {quot_ff[QUOT_BITS-2:0], div_fits};
            step_ff <= step_ff + STEP_BITS'(1);
         end
         nfr_pkg::NORM_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (deposit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (deposit) begin
         rsp_response_ff <= nfr_pkg::sat_response(neg_ff, quot_ff);
         rsp_last_ff     <= last_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_response          = rsp_response_ff;
   assign rsp_last_location_res = rsp_last_ff;

`ifndef SYNTHESIS
   // a new location only arrives while the unit is free
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      handoff.valid |-> (state_ff == nfr_pkg::NORM_IDLE))
      else $error("handoff while normalizer busy");

   // scaled radicand is at least 2^24, so the divisor is never zero
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nfr_pkg::NORM_DIVIDE) |-> (root_ff != '0))
      else $error("zero divisor");

   // a result appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == nfr_pkg::NORM_DONE))
      else $error("result without finished location");
`endif

endmodule

// File: rtl/normalized_feature_response_unit.sv
// ----------------------------------------------------------------------------
// normalized_feature_response_unit
// Per map location, dot product of the features with a stored 1x1 filter,
// divided by the feature vector length, saturated to signed Q16.16.
// ----------------------------------------------------------------------------
//  chan | dir | handshake           | payload
//  req_ | in  | req_valid/req_stall | opcode, weight_index, sample_value, last_location
//  rsp_ | out | rsp_valid/rsp_stall | response, last_location_res
//  csr_ | in  | csr_write_enable    | feature_count (csr_write_data)
//
// Weight loads and non-final features are taken one per cycle. A location's final
// feature reaches the normalizer via stages A and B; it is then busy for check, 32
// square-root steps, 64 divide steps and output, or check and output alone on a zero
// square sum or early saturation; the next final feature stalls till then. Reset is
// synchronous and does not clear the weight store; the user must load it before use
// (unchecked). A stalled result waits in the output register as other items stream.
// ----------------------------------------------------------------------------
module normalized_feature_response_unit (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [nfr_pkg::INDEX_BITS-1:0]         req_weight_index,
   input  logic signed [nfr_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                   req_last_location,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [nfr_pkg::RESP_BITS-1:0]   rsp_response,
   output logic                                   rsp_last_location_res,

   input  logic                                   csr_write_enable,
   input  logic [nfr_pkg::COUNT_BITS-1:0]         csr_write_data
);

   logic [nfr_pkg::COUNT_BITS-1:0] feature_count_ff;
   logic                           is_feature, accept;
   logic                           feature_accept, load_accept;
   logic                           at_end, end_in_flight, norm_busy;
   nfr_pkg::handoff_type           handoff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         feature_count_ff <= nfr_pkg::RESET_FEATURE_COUNT;
      end else if (csr_write_enable) begin
         feature_count_ff <= csr_write_data;
      end
   end

   // a final feature waits until the normalizer can take its location
   assign is_feature     = (req_opcode == nfr_pkg::OP_FEATURE);
   assign req_stall      = is_feature && at_end && (norm_busy || end_in_flight);
   assign accept         = req_valid && !req_stall;
   assign feature_accept = accept && is_feature;
   assign load_accept    = accept && !is_feature;

   nfr_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .feature_accept (feature_accept),
      .load_accept    (load_accept),
      .weight_index   (req_weight_index),
      .sample_value   (req_sample_value),
      .last_location  (req_last_location),
      .feature_count  (feature_count_ff),
      .at_end         (at_end),
      .end_in_flight  (end_in_flight),
      .handoff        (handoff)
   );

   nfr_norm u_norm (
      .clock                 (clock),
      .reset                 (reset),
      .handoff               (handoff),
      .busy                  (norm_busy),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_response          (rsp_response),
      .rsp_last_location_res (rsp_last_location_res)
   );

endmodule

// File: test/normalized_feature_response_unit_tb.sv
// ----------------------------------------------------------------------------
// normalized_feature_response_unit_tb
// Self-checking bench for the normalized feature response unit. Loads the
// filter, walks a directed script of corner cases, then streams random
// weight and feature traffic under several feature counts. A cycle-level
// monitor keeps its own copy of the weights and running sums and predicts
// every response, which is matched in order against the result channel.
// ----------------------------------------------------------------------------
module normalized_feature_response_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 128;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SHOWN_ERRORS  = 10;
   localparam int SCRIPT_ROWS   = 22;

   typedef enum logic [1:0] {
      STEP_LOAD,
      STEP_FEATURE,
      STEP_SET_COUNT
   } step_kind_type;

   // One directed row; want is only used when pinned is set
   typedef struct packed {
      step_kind_type                    kind;
      logic [nfr_pkg::INDEX_BITS-1:0]   index;
      logic [nfr_pkg::SAMPLE_BITS-1:0]  value;
      logic                             last;
      logic                             pinned;
      logic [nfr_pkg::RESP_BITS-1:0]    want;
   } script_row_type;

   typedef struct packed {
      logic [nfr_pkg::RESP_BITS-1:0] response;
      logic                          last;
   } response_type;

   // DUT signals
   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_opcode = 1'b0;
   logic [nfr_pkg::INDEX_BITS-1:0]         req_weight_index = '0;
   logic signed [nfr_pkg::SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                                   req_last_location = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [nfr_pkg::RESP_BITS-1:0]   rsp_response;
   logic                                   rsp_last_location_res;
   logic                                   csr_write_enable = 1'b0;
   logic [nfr_pkg::COUNT_BITS-1:0]         csr_write_data = '0;

   // Typed-in expectation that travels with the item being offered
   logic                          pin_on = 1'b0;
   logic [nfr_pkg::RESP_BITS-1:0] pin_value = '0;

   // Filter and running sums as the block should hold them
   logic [nfr_pkg::SAMPLE_BITS-1:0] filter_taps [nfr_pkg::MAX_FEATURES];
   int unsigned                     location_pos;
   logic [nfr_pkg::ACC_BITS-1:0]    dot_sum;
   logic [nfr_pkg::ACC_BITS-1:0]    square_sum;
   logic [nfr_pkg::COUNT_BITS-1:0]  features_per_location;
   response_type                    pending_responses [$];

   // Per-item scratch for the monitor
   int unsigned                            span;
   logic signed [nfr_pkg::SAMPLE_BITS-1:0] feat_s;
   logic signed [nfr_pkg::SAMPLE_BITS-1:0] tap_s;
   logic signed [nfr_pkg::ACC_BITS-1:0]    term;
   response_type                           due;
   response_type                           got;

   // Bookkeeping
   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  loads_sent     = 0;
   int  features_sent  = 0;
   int  count_writes   = 0;
   int  random_items   = 0;
   bit  quiet          = 1'b0;

   script_row_type script [SCRIPT_ROWS] = '{
      '{STEP_SET_COUNT, 5'd0,  16'd1,    1'b0, 1'b0, 32'h0000_0000},
      '{STEP_LOAD,      5'd0,  16'h0100, 1'b0, 1'b0, 32'h0000_0000},
      // all-zero location: empty square sum passes the dot product through
      '{STEP_FEATURE,   5'd3,  16'h0000, 1'b0, 1'b1, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'h0100, 1'b1, 1'b1, 32'h0001_0000},
      '{STEP_FEATURE,   5'd31, 16'hFF00, 1'b0, 1'b1, 32'hFFFF_0000},
      '{STEP_LOAD,      5'd0,  16'h8000, 1'b0, 1'b0, 32'h0000_0000},
      '{STEP_LOAD,      5'd31, 16'h7FFF, 1'b1, 1'b0, 32'h0000_0000},
      // full-scale samples against full-scale weights
      '{STEP_FEATURE,   5'd0,  16'h8000, 1'b1, 1'b1, 32'h0080_0000},
      '{STEP_FEATURE,   5'd0,  16'h7FFF, 1'b0, 1'b1, 32'hFF80_0000},
      '{STEP_LOAD,      5'd0,  16'h7FFF, 1'b0, 1'b0, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'h7FFF, 1'b1, 1'b1, 32'h007F_FF00},
      '{STEP_FEATURE,   5'd0,  16'h8000, 1'b0, 1'b1, 32'hFF80_0100},
      '{STEP_FEATURE,   5'd0,  16'h0001, 1'b1, 1'b1, 32'h007F_FF00},
      // count of zero behaves as one
      '{STEP_SET_COUNT, 5'd0,  16'd0,    1'b0, 1'b0, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'h0200, 1'b1, 1'b0, 32'h0000_0000},
      '{STEP_SET_COUNT, 5'd0,  16'd3,    1'b0, 1'b0, 32'h0000_0000},
      '{STEP_LOAD,      5'd1,  16'h0080, 1'b0, 1'b0, 32'h0000_0000},
      '{STEP_LOAD,      5'd2,  16'hFFFF, 1'b0, 1'b0, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'h1234, 1'b0, 1'b0, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'hEDCC, 1'b1, 1'b0, 32'h0000_0000},
      // count dropped below the position: next feature closes the location
      '{STEP_SET_COUNT, 5'd0,  16'd1,    1'b0, 1'b0, 32'h0000_0000},
      '{STEP_FEATURE,   5'd0,  16'h0100, 1'b1, 1'b0, 32'h0000_0000}
   };

   normalized_feature_response_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_weight_index      (req_weight_index),
      .req_sample_value      (req_sample_value),
      .req_last_location     (req_last_location),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_response          (rsp_response),
      .rsp_last_location_res (rsp_last_location_res),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // Arithmetic of the response
   // ---------------------------------------------------------------------

   // Signed Q16.16 clamp of a sign and magnitude
   function automatic logic [nfr_pkg::RESP_BITS-1:0] clamp_q16(logic neg, logic [63:0] mag);
      if (neg) begin
         if (mag >= 64'h8000_0000) begin
            return 32'h8000_0000;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   // Floor of the square root, two bits per step
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] probe;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > v) begin
         probe = probe >> 2;
      end
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // dot * 256 / sqrt(squares), or dot itself when squares is zero
   function automatic logic [nfr_pkg::RESP_BITS-1:0] normalized_of(
      logic [nfr_pkg::ACC_BITS-1:0] dot,
      logic [nfr_pkg::ACC_BITS-1:0] sq
   );
      logic signed [63:0] d;
      logic               neg;
      logic [63:0]        mag;
      logic [63:0]        root;
      int                 h;
      d   = {{(64-nfr_pkg::ACC_BITS){dot[nfr_pkg::ACC_BITS-1]}}, dot};
      neg = dot[nfr_pkg::ACC_BITS-1];
      mag = neg ? 64'(-d) : 64'(d);
      if (sq == '0) begin
         return clamp_q16(neg, mag);
      end
      h = (64'(sq) < (64'd1 << 40)) ? 12 : 8;
      // too big to scale means far out of range anyway
      if (mag >= (64'd1 << (63 - (8 + h)))) begin
         return clamp_q16(neg, 64'h1_0000_0000);
      end
      root = floor_root(64'(sq) << (2 * h));
      if (root == 0) begin
         return clamp_q16(neg, 64'h1_0000_0000);
      end
      return clamp_q16(neg, (mag << (8 + h)) / root);
   endfunction

   // ---------------------------------------------------------------------
   // Result receiver: random stall, none during the quiet stretch
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 29);
      end
   end

   task automatic note_mismatch(string what, logic [nfr_pkg::RESP_BITS-1:0] want,
                                logic [nfr_pkg::RESP_BITS-1:0] seen);
      if (mismatch_count < SHOWN_ERRORS) begin
         $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, seen);
      end
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: checks results, then tracks config writes and accepted items
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         location_pos          = 0;
         dot_sum               = '0;
         square_sum            = '0;
         features_per_location = nfr_pkg::RESET_FEATURE_COUNT;
      end else begin
         // result side
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got = '{rsp_response, rsp_last_location_res};
            if (pending_responses.size() == 0) begin
               note_mismatch("unexpected response", '0, got.response);
            end else begin
               due = pending_responses.pop_front();
               if (got.response !== due.response) begin
                  note_mismatch("response", due.response, got.response);
               end
               if (got.last !== due.last) begin
                  note_mismatch("last_location_res", 32'(due.last), 32'(got.last));
               end
            end
         end

         if (csr_write_enable) begin
            features_per_location = csr_write_data;
         end

         // request side
         if (req_valid && !req_stall) begin
            if (req_opcode == nfr_pkg::OP_LOAD) begin
               filter_taps[req_weight_index[nfr_pkg::POS_BITS-1:0]] = req_sample_value;
            end else begin
               span = 32'(features_per_location);
               if (span == 0) begin
                  span = 1;
               end else if (span > nfr_pkg::MAX_FEATURES) begin
                  span = nfr_pkg::MAX_FEATURES;
               end
               feat_s     = req_sample_value;
               tap_s      = filter_taps[location_pos[nfr_pkg::POS_BITS-1:0]];
               term       = feat_s * tap_s;
               dot_sum    = dot_sum + term;
               term       = feat_s * feat_s;
               square_sum = square_sum + term;
               if (location_pos + 1 >= span) begin
                  due.response = pin_on ? pin_value : normalized_of(dot_sum, square_sum);
                  due.last     = req_last_location;
                  pending_responses.push_back(due);
                  location_pos = 0;
                  dot_sum      = '0;
                  square_sum   = '0;
               end else begin
                  location_pos++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one item after a random gap and hold it until accepted
   task automatic push_item(nfr_pkg::opcode_type op, logic [nfr_pkg::INDEX_BITS-1:0] idx,
                            logic [nfr_pkg::SAMPLE_BITS-1:0] val, logic last,
                            logic pinned, logic [nfr_pkg::RESP_BITS-1:0] want);
      while (!quiet && ($urandom_range(99) < 29)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_weight_index  <= idx;
      req_sample_value  <= val;
      req_last_location <= last;
      pin_on            <= pinned;
      pin_value         <= want;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (op == nfr_pkg::OP_LOAD) begin
         loads_sent++;
      end else begin
         features_sent++;
      end
   endtask

   // Stop offering, wait for every predicted response, then let the back end settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_feature_count(logic [nfr_pkg::COUNT_BITS-1:0] count);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_writes++;
   endtask

   function automatic logic [nfr_pkg::SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'h0001;
               3:       return 16'hFFFF;
               default: return 16'h0000;
            endcase
         end
         1:       return 16'($urandom_range(511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random weight and feature traffic across a series of feature counts
   task automatic run_random_traffic();
      int                              phase;
      int                              zero_left;
      logic [nfr_pkg::COUNT_BITS-1:0]  count;
      logic [nfr_pkg::SAMPLE_BITS-1:0] value;
      phase     = 0;
      zero_left = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0:       count = 6'd32;
            1:       count = 6'd63;
            2:       count = 6'd2;
            3:       count = 6'd0;
            4:       count = 6'd1;
            5:       count = 6'd31;
            default: count = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                      : 6'($urandom_range(1, 8));
         endcase
         set_feature_count(count);
         quiet = (phase == 2);
         repeat ($urandom_range(80, 160)) begin
            if ($urandom_range(7) == 0) begin
               push_item(nfr_pkg::OP_LOAD, 5'($urandom), random_sample(), 1'($urandom),
                         1'b0, '0);
            end else begin
               // an occasional zero run covers whole silent locations
               if (zero_left == 0 && $urandom_range(199) == 0) begin
                  zero_left = 40;
               end
               if (zero_left > 0) begin
                  value = '0;
                  zero_left--;
               end else begin
                  value = random_sample();
               end
               push_item(nfr_pkg::OP_FEATURE, 5'($urandom), value, 1'($urandom), 1'b0, '0);
            end
            random_items++;
         end
         quiet = 1'b0;
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill every filter slot before any feature reads it
      for (int i = 0; i < nfr_pkg::MAX_FEATURES; i++) begin
         push_item(nfr_pkg::OP_LOAD, 5'(i),
                   (i == 0) ? 16'h7FFF : (i == 1) ? 16'h8000 : random_sample(),
                   1'($urandom), 1'b0, '0);
      end

      // one location at the count left by reset
      repeat (nfr_pkg::RESET_FEATURE_COUNT) begin
         push_item(nfr_pkg::OP_FEATURE, 5'($urandom), random_sample(), 1'($urandom),
                   1'b0, '0);
      end

      foreach (script[i]) begin
         case (script[i].kind)
            STEP_SET_COUNT: set_feature_count(script[i].value[nfr_pkg::COUNT_BITS-1:0]);
            STEP_LOAD:      push_item(nfr_pkg::OP_LOAD, script[i].index, script[i].value,
                                      script[i].last, 1'b0, '0);
            default:        push_item(nfr_pkg::OP_FEATURE, script[i].index, script[i].value,
                                      script[i].last, script[i].pinned, script[i].want);
         endcase
      end

      run_random_traffic();
      drain_responses();

      $display("Sent %0d weight loads and %0d features over %0d feature-count settings;",
               loads_sent, features_sent, count_writes);
      $display("checked %0d responses in %0d cycles, %0d mismatches.",
               results_seen, cycle_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d responses outstanding.",
               cycle_count, pending_responses.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/nfr_pkg.sv
rtl/nfr_weight_ram.sv
rtl/nfr_accum.sv
rtl/nfr_norm.sv
rtl/normalized_feature_response_unit.sv
test/normalized_feature_response_unit_tb.sv
